[rtl/core/tuv_pkg.sv]
// Shared types, constants and the arctangent table function for the texture projection block.
package tuv_pkg;

  localparam int IN_W         = 32;
  localparam int CIN_W        = 33;
  localparam int CORD_W       = 52;
  localparam int CORD_SHIFT   = 16;
  localparam int ANG_W        = 34;
  localparam int ANG_FRAC     = 24;
  localparam int MAG_W        = 33;
  localparam int SPAN_W       = 25;
  localparam int DIV_W        = 26;
  localparam int TABLE_LEN    = 32;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int SQRT_STAGES  = 32;
  localparam int CFG_AW       = 4;
  localparam int CFG_DW       = 32;

  localparam logic [SPAN_W-1:0] U_SPAN_RESET = 25'd23592960;
  localparam logic [SPAN_W-1:0] V_SPAN_RESET = 25'd11796480;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_PLANAR = 2'd1,
    MODE_CYL    = 2'd2,
    MODE_SPH    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_U_SPAN = 2'd1,
    REG_V_SPAN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic signed [IN_W-1:0] cx;
    logic signed [IN_W-1:0] cz;
  } point_t;

  // Unsigned long division by shift and subtract, used only while building the table.
  function automatic longint unsigned div_const(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees with 24 fraction bits, from the arctangent series.
  function automatic longint atan_deg(input int i);
    longint          acc;
    longint          term;
    longint unsigned s;
    int              sh;
    acc = 0;
    if (i == 0) begin
      return longint'(45) <<< ANG_FRAC;
    end
    for (int k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh < 61) begin
        term = longint'(div_const((64'd1 << 60) >> sh, 64'(2 * k + 1)));
        acc  = ((k & 1) == 1) ? acc - term : acc + term;
      end
    end
    s = longint'(acc);
    return longint'(((s >> 24) * 64'd60078979) >> 32);
  endfunction

endpackage

[rtl/core/tuv_ifs.sv]
// Valid/ready channel interfaces for input points and texture results.
interface tuv_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        point_x;
  logic signed [31:0]        point_y;
  logic signed [31:0]        point_z;
  logic signed [31:0]        centroid_x;
  logic signed [31:0]        centroid_z;

  modport source (output valid, point_x, point_y, point_z, centroid_x, centroid_z,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_z, centroid_x, centroid_z,
                  output ready);
endinterface

interface tuv_out_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        tex_u;
  logic signed [31:0]        tex_v;
  logic                      status;

  modport source (output valid, tex_u, tex_v, status, input ready);
  modport sink   (input valid, tex_u, tex_v, status, output ready);
endinterface

[rtl/core/texture_uv_projection.sv]
// Top level of the texture projection block: registers, pipeline and seam correction.
//
// Points arrive on in_ch and texture coordinates leave on out_ch, one word per
// accepted point and in the same order. The projection mode and the two angular
// spans are set through the cfg_ APB port at byte addresses 0, 4 and 8. The user
// must change them only while the pipeline holds no work; the block does not enforce it.
//
// The pipeline accepts one point per cycle while out_ch is not stalled. It is
// built from the squaring and summing registers, 32 square-root stages,
// ANGLE_STAGES + 1 CORDIC stages, FRAC_BITS + 35 divider stages and the seam
// correction and output saturation registers. Latency is dominated by the
// one-bit-per-stage divider and root.
//
// When the receiver holds out_ch.ready low with a word waiting, the whole
// pipeline freezes and in_ch.ready drops in the same cycle; nothing is lost or
// repeated. Reset clears every valid bit and restores the register defaults
// (mode off, spans of 360 and 180 degrees).
module texture_uv_projection #(
  parameter int FRAC_BITS    = 16,
  parameter int ANGLE_STAGES = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tuv_in_if.sink                        in_ch,
  tuv_out_if.source                     out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tuv_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [tuv_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [tuv_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import tuv_pkg::*;

  localparam int DW = MAG_W + FRAC_BITS;
  localparam int QW = DW + 1;
  localparam int EW = QW + 2;
  localparam int PT_W = $bits(point_t);
  localparam int XY_W = 2 * IN_W;
  localparam logic [ROOT_W-1:0] POLE_LIMIT = ROOT_W'(((1 << FRAC_BITS) + 50) / 100);
  localparam logic signed [EW-1:0] HALF = EW'(1) <<< (ANG_FRAC - 1);
  localparam logic signed [EW-1:0] WHOLE_MASK = ~((EW'(1) <<< ANG_FRAC) - EW'(1));
  localparam logic signed [EW:0] OUT_MAX = (EW+1)'(32'sh7fffffff);
  localparam logic signed [EW:0] OUT_MIN = -(EW+1)'(33'sh080000000);

  mode_t             mode_r;
  logic [SPAN_W-1:0] u_span_r;
  logic [SPAN_W-1:0] v_span_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;
  logic              en;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      u_span_r <= U_SPAN_RESET;
      v_span_r <= V_SPAN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:   mode_r   <= mode_t'(cfg_pwdata[1:0]);
        REG_U_SPAN: u_span_r <= cfg_pwdata[SPAN_W-1:0];
        REG_V_SPAN: v_span_r <= cfg_pwdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:   cfg_prdata = CFG_DW'(mode_r);
      REG_U_SPAN: cfg_prdata = CFG_DW'(u_span_r);
      REG_V_SPAN: cfg_prdata = CFG_DW'(v_span_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Squares of x and z, then their sum.
  point_t            pt_in;
  logic              s0_vld_r, s1_vld_r;
  point_t            s0_pt_r, s1_pt_r;
  logic signed [RAD_W-1:0] sqx_r, sqz_r;
  logic [RAD_W-1:0]  sum_r;

  assign pt_in = '{x: in_ch.point_x, y: in_ch.point_y, z: in_ch.point_z,
                   cx: in_ch.centroid_x, cz: in_ch.centroid_z};
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r   <= RAD_W'(pt_in.x) * RAD_W'(pt_in.x);
      sqz_r   <= RAD_W'(pt_in.z) * RAD_W'(pt_in.z);
      s0_pt_r <= pt_in;
      sum_r   <= RAD_W'(sqx_r) + RAD_W'(sqz_r);
      s1_pt_r <= s0_pt_r;
    end
  end

  logic              sq_vld;
  logic [ROOT_W-1:0] len;
  logic [PT_W-1:0]   sq_side;
  point_t            sq_pt;
  logic              pole;

  tuv_sqrt #(.SIDE_W(PT_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (s1_vld_r),
    .n_i    (sum_r),
    .side_i (s1_pt_r),
    .vld_o  (sq_vld),
    .root_o (len),
    .side_o (sq_side)
  );

  assign sq_pt = point_t'(sq_side);
  assign pole  = len < POLE_LIMIT;

  logic                    cu_vld;
  logic signed [ANG_W-1:0] ang_u, ang_c, ang_v;
  logic [XY_W-1:0]         cu_side;

  tuv_cordic #(.SIDE_W(XY_W), .STAGES(ANGLE_STAGES)) u_cordic_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (sq_vld),
    .a_i     (CIN_W'(pole ? sq_pt.cx : sq_pt.x)),
    .b_i     (CIN_W'(pole ? sq_pt.cz : sq_pt.z)),
    .side_i  ({sq_pt.x, sq_pt.y}),
    .vld_o   (cu_vld),
    .angle_o (ang_u),
    .side_o  (cu_side)
  );

  tuv_cordic #(.SIDE_W(1), .STAGES(ANGLE_STAGES)) u_cordic_c (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (sq_vld),
    .a_i     (CIN_W'(sq_pt.cx)),
    .b_i     (CIN_W'(sq_pt.cz)),
    .side_i  (1'b0),
    .vld_o   (),
    .angle_o (ang_c),
    .side_o  ()
  );

  tuv_cordic #(.SIDE_W(1), .STAGES(ANGLE_STAGES)) u_cordic_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (sq_vld),
    .a_i     (CIN_W'(sq_pt.y)),
    .b_i     ($signed({1'b0, len})),
    .side_i  (1'b0),
    .vld_o   (),
    .angle_o (ang_v),
    .side_o  ()
  );

  logic                 du_vld;
  logic signed [QW-1:0] qu, qc, qv;
  logic [XY_W-1:0]      du_side;
  logic                 sph;

  assign sph = mode_r == MODE_SPH;

  tuv_div #(.SIDE_W(XY_W), .FRAC_BITS(FRAC_BITS)) u_div_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (cu_vld),
    .angle_i (ang_u),
    .span_i  (u_span_r),
    .twice_i (sph),
    .side_i  (cu_side),
    .vld_o   (du_vld),
    .quot_o  (qu),
    .side_o  (du_side)
  );

  tuv_div #(.SIDE_W(1), .FRAC_BITS(FRAC_BITS)) u_div_c (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (cu_vld),
    .angle_i (ang_c),
    .span_i  (u_span_r),
    .twice_i (sph),
    .side_i  (1'b0),
    .vld_o   (),
    .quot_o  (qc),
    .side_o  ()
  );

  tuv_div #(.SIDE_W(1), .FRAC_BITS(FRAC_BITS)) u_div_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (cu_vld),
    .angle_i (ang_v),
    .span_i  (v_span_r),
    .twice_i (1'b1),
    .side_i  (1'b0),
    .vld_o   (),
    .quot_o  (qv),
    .side_o  ()
  );

  // Seam correction and output saturation.
  function automatic logic signed [IN_W-1:0] sat_out(input logic signed [EW:0] q);
    logic signed [EW:0] v;
    v = q >>> (ANG_FRAC - FRAC_BITS);
    if (v > OUT_MAX) begin
      return IN_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      return IN_W'(OUT_MIN);
    end
    return IN_W'(v);
  endfunction

  logic                 t0_vld_r, t1_vld_r, out_vld_r;
  logic signed [EW-1:0] t0_u_r, t0_d_r, t0_v_r;
  logic signed [EW-1:0] t1_u_r, t1_v_r;
  logic [XY_W-1:0]      t0_xy_r, t1_xy_r;
  logic signed [EW-1:0] u_adj_nxt;
  logic signed [IN_W-1:0] tex_u_r, tex_v_r, tex_u_nxt, tex_v_nxt;
  logic                 status_r, status_nxt;
  logic signed [IN_W-1:0] t1_x, t1_y;

  assign en = !out_vld_r || out_ch.ready;

  always_comb begin
    if (t0_d_r > HALF) begin
      u_adj_nxt = t0_u_r - ((t0_d_r + HALF) & WHOLE_MASK);
    end else if (t0_d_r < -HALF) begin
      u_adj_nxt = t0_u_r + ((HALF - t0_d_r) & WHOLE_MASK);
    end else begin
      u_adj_nxt = t0_u_r;
    end
  end

  assign t1_x = t1_xy_r[XY_W-1:IN_W];
  assign t1_y = t1_xy_r[IN_W-1:0];

  always_comb begin
    tex_u_nxt  = '0;
    tex_v_nxt  = '0;
    status_nxt = 1'b0;
    unique case (mode_r)
      MODE_OFF: begin
        status_nxt = 1'b1;
      end
      MODE_PLANAR: begin
        tex_u_nxt = t1_x;
        tex_v_nxt = t1_y;
      end
      MODE_CYL: begin
        tex_u_nxt = sat_out((EW+1)'(t1_u_r) - (EW+1)'(HALF));
        tex_v_nxt = t1_y;
      end
      MODE_SPH: begin
        tex_u_nxt = sat_out((EW+1)'(t1_u_r) - (EW+1)'(HALF));
        tex_v_nxt = sat_out((EW+1)'(t1_v_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_vld_r  <= 1'b0;
      t1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      t0_vld_r  <= du_vld;
      t1_vld_r  <= t0_vld_r;
      out_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_u_r   <= EW'(qu);
      t0_d_r   <= EW'(qu) - EW'(qc);
      t0_v_r   <= EW'(qv);
      t0_xy_r  <= du_side;
      t1_u_r   <= u_adj_nxt;
      t1_v_r   <= t0_v_r - HALF;
      t1_xy_r  <= t0_xy_r;
      tex_u_r  <= tex_u_nxt;
      tex_v_r  <= tex_v_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.tex_u  = tex_u_r;
  assign out_ch.tex_v  = tex_v_r;
  assign out_ch.status = status_r;

endmodule

[rtl/core/tuv_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module tuv_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [tuv_pkg::RAD_W-1:0]   n_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [tuv_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]           side_o
);
  import tuv_pkg::*;

  logic [RAD_W-1:0]  rem_r  [SQRT_STAGES];
  logic [RAD_W-1:0]  root_r [SQRT_STAGES];
  logic [SIDE_W-1:0] side_r [SQRT_STAGES];
  logic              vld_r  [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [RAD_W-1:0]  rem_prev;
    logic [RAD_W-1:0]  root_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              vld_prev;
    logic [RAD_W-1:0]  trial;
    logic [RAD_W-1:0]  rem_nxt;
    logic [RAD_W-1:0]  root_nxt;
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * s);

    if (s == 0) begin : g_first
      assign rem_prev  = n_i;
      assign root_prev = '0;
      assign side_prev = side_i;
      assign vld_prev  = vld_i;
    end else begin : g_next
      assign rem_prev  = rem_r[s-1];
      assign root_prev = root_r[s-1];
      assign side_prev = side_r[s-1];
      assign vld_prev  = vld_r[s-1];
    end

    always_comb begin
      trial = root_prev + BIT;
      if (rem_prev >= trial) begin
        rem_nxt  = rem_prev - trial;
        root_nxt = (root_prev >> 1) + BIT;
      end else begin
        rem_nxt  = rem_prev;
        root_nxt = root_prev >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        side_r[s] <= side_prev;
      end
    end
  end

  assign vld_o  = vld_r[SQRT_STAGES-1];
  assign root_o = root_r[SQRT_STAGES-1][ROOT_W-1:0];
  assign side_o = side_r[SQRT_STAGES-1];

endmodule

[rtl/core/tuv_cordic.sv]
// Pipelined vectoring CORDIC that returns atan2(a, b) in degrees.
module tuv_cordic #(
  parameter int SIDE_W = 1,
  parameter int STAGES = 18
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             vld_i,
  input  logic signed [tuv_pkg::CIN_W-1:0] a_i,
  input  logic signed [tuv_pkg::CIN_W-1:0] b_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             vld_o,
  output logic signed [tuv_pkg::ANG_W-1:0] angle_o,
  output logic [SIDE_W-1:0]                side_o
);
  import tuv_pkg::*;

  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(90) <<< ANG_FRAC;

  logic signed [CORD_W-1:0] x_r    [STAGES+1];
  logic signed [CORD_W-1:0] y_r    [STAGES+1];
  logic signed [ANG_W-1:0]  acc_r  [STAGES+1];
  logic                     zero_r [STAGES+1];
  logic [SIDE_W-1:0]        side_r [STAGES+1];
  logic                     vld_r  [STAGES+1];

  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [CORD_W-1:0] x0_nxt;
  logic signed [CORD_W-1:0] y0_nxt;
  logic signed [ANG_W-1:0]  acc0_nxt;

  always_comb begin
    xs = CORD_W'(b_i) <<< CORD_SHIFT;
    ys = CORD_W'(a_i) <<< CORD_SHIFT;
    x0_nxt   = xs;
    y0_nxt   = ys;
    acc0_nxt = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0_nxt   = ys;
        y0_nxt   = -xs;
        acc0_nxt = QUARTER;
      end else begin
        x0_nxt   = -ys;
        y0_nxt   = xs;
        acc0_nxt = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      acc_r[0]  <= acc0_nxt;
      zero_r[0] <= (a_i == '0) && (b_i == '0);
      side_r[0] <= side_i;
    end
  end

  for (genvar i = 1; i <= STAGES; i++) begin : g_stage
    localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_deg(i - 1));
    logic signed [CORD_W-1:0] dx;
    logic signed [CORD_W-1:0] dy;
    logic signed [CORD_W-1:0] x_nxt;
    logic signed [CORD_W-1:0] y_nxt;
    logic signed [ANG_W-1:0]  acc_nxt;

    always_comb begin
      dx = y_r[i-1] >>> (i - 1);
      dy = x_r[i-1] >>> (i - 1);
      if (y_r[i-1] >= 0) begin
        x_nxt   = x_r[i-1] + dx;
        y_nxt   = y_r[i-1] - dy;
        acc_nxt = acc_r[i-1] + ATAN;
      end else begin
        x_nxt   = x_r[i-1] - dx;
        y_nxt   = y_r[i-1] + dy;
        acc_nxt = acc_r[i-1] - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        acc_r[i]  <= acc_nxt;
        zero_r[i] <= zero_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign vld_o   = vld_r[STAGES];
  assign angle_o = zero_r[STAGES] ? '0 : acc_r[STAGES];
  assign side_o  = side_r[STAGES];

endmodule

[rtl/core/tuv_div.sv]
// Pipelined signed divider that divides an angle by the span, one quotient bit per stage.
module tuv_div #(
  parameter int SIDE_W    = 1,
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  logic                                       vld_i,
  input  logic signed [tuv_pkg::ANG_W-1:0]           angle_i,
  input  logic [tuv_pkg::SPAN_W-1:0]                 span_i,
  input  logic                                       twice_i,
  input  logic [SIDE_W-1:0]                          side_i,
  output logic                                       vld_o,
  output logic signed [tuv_pkg::MAG_W+FRAC_BITS:0]   quot_o,
  output logic [SIDE_W-1:0]                          side_o
);
  import tuv_pkg::*;

  localparam int DW = MAG_W + FRAC_BITS;
  localparam int QW = DW + 1;

  logic [DIV_W-1:0]        dvs;
  logic [ANG_W-1:0]        mag;

  logic [DIV_W-1:0]        rem_r  [DW+1];
  logic [DW-1:0]           n_r    [DW+1];
  logic [DW-1:0]           q_r    [DW+1];
  logic                    neg_r  [DW+1];
  logic [SIDE_W-1:0]       side_r [DW+2];
  logic                    vld_r  [DW+2];
  logic signed [QW-1:0]    quot_r;

  always_comb begin
    dvs = DIV_W'((span_i == '0) ? SPAN_W'(1) : span_i) << twice_i;
    mag = (angle_i < 0) ? ANG_W'(-angle_i) : ANG_W'(angle_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      n_r[0]    <= DW'(mag[MAG_W-1:0]) << FRAC_BITS;
      q_r[0]    <= '0;
      neg_r[0]  <= angle_i < 0;
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= DW; k++) begin : g_stage
    logic [DIV_W:0]   trial;
    logic             ge;
    logic [DIV_W-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[k-1], n_r[k-1][DW-1]};
      ge      = trial >= {1'b0, dvs};
      rem_nxt = ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        n_r[k]    <= n_r[k-1] << 1;
        q_r[k]    <= {q_r[k-1][DW-2:0], ge};
        neg_r[k]  <= neg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[DW+1] <= 1'b0;
    end else if (en) begin
      vld_r[DW+1] <= vld_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot_r       <= neg_r[DW] ? -$signed({1'b0, q_r[DW]}) : $signed({1'b0, q_r[DW]});
      side_r[DW+1] <= side_r[DW];
    end
  end

  assign vld_o  = vld_r[DW+1];
  assign quot_o = quot_r;
  assign side_o = side_r[DW+1];

endmodule

[rtl/core/tuv_checker.sv]
// Port-level checks for the texture projection block, bound to its top level.
module tuv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] tex_u,
  input logic signed [31:0] tex_v,
  input logic               status
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result word present right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(tex_u) && $stable(tex_v)
      && $stable(status))
    else $error("Stalled result word changed.");

  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> tex_u == 0 && tex_v == 0)
    else $error("Word marked off carries nonzero coordinates.");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("Input ready does not follow the output stall.");

endmodule

bind texture_uv_projection tuv_checker u_tuv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .tex_u     (out_ch.tex_u),
  .tex_v     (out_ch.tex_v),
  .status    (out_ch.status)
);
